>>> sv/alu8m_pkg.sv
// Shared types and constants for the 8-bit multi-operation ALU.
package alu8m_pkg;

    localparam logic [7:0] OPC_SADD = 8'd0;
    localparam logic [7:0] OPC_SSUB = 8'd1;
    localparam logic [7:0] OPC_NEG  = 8'd2;
    localparam logic [7:0] OPC_EQ   = 8'd3;
    localparam logic [7:0] OPC_LT   = 8'd4;
    localparam logic [7:0] OPC_GT   = 8'd5;
    localparam logic [7:0] OPC_AND  = 8'd6;
    localparam logic [7:0] OPC_OR   = 8'd7;
    localparam logic [7:0] OPC_SHL  = 8'd8;
    localparam logic [7:0] OPC_SHR  = 8'd9;
    localparam logic [7:0] OPC_UMUL = 8'd10;
    localparam logic [7:0] OPC_SMUL = 8'd11;
    localparam logic [7:0] OPC_UDIV = 8'd12;
    localparam logic [7:0] OPC_SDIV = 8'd13;
    localparam logic [7:0] OPC_ADD  = 8'd16;
    localparam logic [7:0] OPC_SUB  = 8'd17;

    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW = 2'd1;
    localparam logic [1:0] ERR_DIV_ZERO = 2'd2;

    typedef enum logic [4:0] {
        OP_SADD,
        OP_SSUB,
        OP_NEG,
        OP_EQ,
        OP_LT,
        OP_GT,
        OP_AND,
        OP_OR,
        OP_SHL,
        OP_SHR,
        OP_UMUL,
        OP_SMUL,
        OP_UDIV,
        OP_SDIV,
        OP_ADD,
        OP_SUB,
        OP_NONE
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] a;
        logic [7:0] b;
    } t_item;

    typedef struct packed {
        logic [15:0] value;
        logic        wide;
        logic [1:0]  err;
    } t_res;

endpackage

>>> sv/alu8m_front.sv
// Front end: takes input beats and decodes the opcode into an operation class.
module alu8m_front (
    input  logic                i_valid,
    input  logic [7:0]          i_opcode,
    input  logic [7:0]          i_a,
    input  logic [7:0]          i_b,
    input  logic                i_queue_full,
    output logic                o_ready,
    output logic                o_push,
    output alu8m_pkg::t_item    o_item
);

    alu8m_pkg::t_op n_op;

    always_comb begin
        unique case (i_opcode)
            alu8m_pkg::OPC_SADD: n_op = alu8m_pkg::OP_SADD;
            alu8m_pkg::OPC_SSUB: n_op = alu8m_pkg::OP_SSUB;
            alu8m_pkg::OPC_NEG:  n_op = alu8m_pkg::OP_NEG;
            alu8m_pkg::OPC_EQ:   n_op = alu8m_pkg::OP_EQ;
            alu8m_pkg::OPC_LT:   n_op = alu8m_pkg::OP_LT;
            alu8m_pkg::OPC_GT:   n_op = alu8m_pkg::OP_GT;
            alu8m_pkg::OPC_AND:  n_op = alu8m_pkg::OP_AND;
            alu8m_pkg::OPC_OR:   n_op = alu8m_pkg::OP_OR;
            alu8m_pkg::OPC_SHL:  n_op = alu8m_pkg::OP_SHL;
            alu8m_pkg::OPC_SHR:  n_op = alu8m_pkg::OP_SHR;
            alu8m_pkg::OPC_UMUL: n_op = alu8m_pkg::OP_UMUL;
            alu8m_pkg::OPC_SMUL: n_op = alu8m_pkg::OP_SMUL;
            alu8m_pkg::OPC_UDIV: n_op = alu8m_pkg::OP_UDIV;
            alu8m_pkg::OPC_SDIV: n_op = alu8m_pkg::OP_SDIV;
            alu8m_pkg::OPC_ADD:  n_op = alu8m_pkg::OP_ADD;
            alu8m_pkg::OPC_SUB:  n_op = alu8m_pkg::OP_SUB;
            default:             n_op = alu8m_pkg::OP_NONE;
        endcase
    end

    assign o_ready   = !i_queue_full;
    assign o_push    = i_valid && !i_queue_full;
    assign o_item.op = n_op;
    assign o_item.a  = i_a;
    assign o_item.b  = i_b;

endmodule

>>> sv/alu8m_fifo.sv
// Short queue of decoded operations between the front end and the execution pipeline.
module alu8m_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  alu8m_pkg::t_item    i_item,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_empty,
    output alu8m_pkg::t_item    o_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    alu8m_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             n_push;
    logic             n_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd];
    assign n_push  = i_push && !o_full;
    assign n_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (n_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (n_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (n_push && !n_pop) begin
                r_count <= r_count + 1'b1;
            end else if (n_pop && !n_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

>>> sv/alu8m_back.sv
// Execution pipeline: narrow operations and multiply, then an eight-stage restoring divider.
module alu8m_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  alu8m_pkg::t_item    i_item,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output alu8m_pkg::t_res     o_res
);

    localparam int STAGES = 8;

    typedef struct packed {
        logic        is_div;
        logic        neg_q;
        logic        neg_r;
        logic [15:0] value;
        logic        wide;
        logic [1:0]  err;
        logic [7:0]  rem;
        logic [7:0]  dq;
        logic [7:0]  dvs;
    } t_stage;

    t_stage          r_pipe [STAGES];
    logic            r_v    [STAGES];
    logic            n_en   [STAGES];
    logic            n_en_out;
    alu8m_pkg::t_res r_out;
    logic            r_out_v;

    function automatic logic [7:0] f_abs(input logic [7:0] v);
        return v[7] ? (8'd0 - v) : v;
    endfunction

    function automatic t_stage f_prep(input alu8m_pkg::t_item it);
        t_stage      s;
        logic [8:0]  sum;
        logic [15:0] prod;
        s       = '0;
        s.err   = alu8m_pkg::ERR_OK;
        s.rem   = '0;
        s.dq    = it.a;
        s.dvs   = it.b;
        unique case (it.op)
            alu8m_pkg::OP_SADD: begin
                sum     = {it.a[7], it.a} + {it.b[7], it.b};
                s.value = {8'd0, sum[7:0]};
                if (sum[8] != sum[7]) begin
                    s.err = alu8m_pkg::ERR_OVERFLOW;
                end
            end
            alu8m_pkg::OP_SSUB: begin
                sum     = {it.a[7], it.a} - {it.b[7], it.b};
                s.value = {8'd0, sum[7:0]};
                if (sum[8] != sum[7]) begin
                    s.err = alu8m_pkg::ERR_OVERFLOW;
                end
            end
            alu8m_pkg::OP_NEG: s.value = {8'd0, 8'd0 - it.a};
            alu8m_pkg::OP_EQ:  s.value = {15'd0, it.a == it.b};
            alu8m_pkg::OP_LT:  s.value = {15'd0, it.a < it.b};
            alu8m_pkg::OP_GT:  s.value = {15'd0, it.a > it.b};
            alu8m_pkg::OP_AND: s.value = {8'd0, it.a & it.b};
            alu8m_pkg::OP_OR:  s.value = {8'd0, it.a | it.b};
            alu8m_pkg::OP_SHL: begin
                s.value = (|it.b[7:3]) ? 16'd0 : {8'd0, it.a << it.b[2:0]};
            end
            alu8m_pkg::OP_SHR: begin
                s.value = (|it.b[7:3]) ? 16'd0 : {8'd0, it.a >> it.b[2:0]};
            end
            alu8m_pkg::OP_UMUL: begin
                s.wide  = 1'b1;
                s.value = {8'd0, it.a} * {8'd0, it.b};
            end
            alu8m_pkg::OP_SMUL: begin
                s.wide  = 1'b1;
                prod    = {{8{it.a[7]}}, it.a} * {{8{it.b[7]}}, it.b};
                s.value = prod;
            end
            alu8m_pkg::OP_UDIV: begin
                s.wide = 1'b1;
                if (it.b == 8'd0) begin
                    s.err = alu8m_pkg::ERR_DIV_ZERO;
                end else begin
                    s.is_div = 1'b1;
                end
            end
            alu8m_pkg::OP_SDIV: begin
                s.wide = 1'b1;
                s.dq   = f_abs(it.a);
                s.dvs  = f_abs(it.b);
                if (it.b == 8'd0) begin
                    s.err = alu8m_pkg::ERR_DIV_ZERO;
                end else begin
                    s.is_div = 1'b1;
                    s.neg_q  = it.a[7] ^ it.b[7];
                    s.neg_r  = it.a[7];
                end
            end
            alu8m_pkg::OP_ADD: s.value = {8'd0, it.a + it.b};
            alu8m_pkg::OP_SUB: s.value = {8'd0, it.a - it.b};
            default:           s.value = 16'd0;
        endcase
        return s;
    endfunction

    // One quotient bit per stage: shift in the next dividend bit and try to subtract.
    function automatic t_stage f_step(input t_stage s);
        t_stage     o;
        logic [8:0] trial;
        logic [8:0] diff;
        o     = s;
        trial = {s.rem, s.dq[7]};
        diff  = trial - {1'b0, s.dvs};
        if (trial >= {1'b0, s.dvs}) begin
            o.rem = diff[7:0];
            o.dq  = {s.dq[6:0], 1'b1};
        end else begin
            o.rem = trial[7:0];
            o.dq  = {s.dq[6:0], 1'b0};
        end
        return o;
    endfunction

    function automatic alu8m_pkg::t_res f_finish(input t_stage s);
        alu8m_pkg::t_res r;
        logic [7:0]      q;
        logic [7:0]      m;
        q       = s.neg_q ? (8'd0 - s.dq) : s.dq;
        m       = s.neg_r ? (8'd0 - s.rem) : s.rem;
        r.value = s.is_div ? {m, q} : s.value;
        r.wide  = s.wide;
        r.err   = s.err;
        return r;
    endfunction

    assign n_en_out = !r_out_v || i_ready;

    always_comb begin
        n_en[STAGES-1] = !r_v[STAGES-1] || n_en_out;
        for (int k = STAGES - 2; k >= 0; k--) begin
            n_en[k] = !r_v[k] || n_en[k+1];
        end
    end

    assign o_pop   = n_en[0] && !i_empty;
    assign o_valid = r_out_v;
    assign o_res   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            for (int k = 0; k < STAGES; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            if (n_en_out) begin
                r_out_v <= r_v[STAGES-1];
            end
            for (int k = 1; k < STAGES; k++) begin
                if (n_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (n_en[0]) begin
                r_v[0] <= !i_empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en_out) begin
            r_out <= f_finish(f_step(r_pipe[STAGES-1]));
        end
        for (int k = 1; k < STAGES; k++) begin
            if (n_en[k]) begin
                r_pipe[k] <= f_step(r_pipe[k-1]);
            end
        end
        if (n_en[0]) begin
            r_pipe[0] <= f_prep(i_item);
        end
    end

endmodule

>>> sv/alu_8bit_multiop.sv
// Top level of the 8-bit multi-operation ALU.
// The block takes one beat per clock cycle while the queue has room and gives exactly one
// result beat for each, in order. Every operation passes through the eight-stage restoring
// divider, which lies between the decoded-operation queue and the output register. Either side
// may stall on its own: the queue holds up to QUEUE_DEPTH decoded beats in front of the
// execution pipeline, and the input stays ready while the queue has room.
module alu_8bit_multiop #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // operand_a [7:0], operand_b [15:8]
    input  logic [7:0]  i_s_axis_tuser,   // opcode [7:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // result_value [15:0]
    output logic [2:0]  o_m_axis_tuser    // result_is_wide [0], error_code [2:1]
);

    alu8m_pkg::t_item front_item;
    alu8m_pkg::t_item queue_item;
    alu8m_pkg::t_res  back_res;
    logic             front_push;
    logic             queue_full;
    logic             queue_empty;
    logic             back_pop;

    alu8m_front u_front (
        .i_valid      (i_s_axis_tvalid),
        .i_opcode     (i_s_axis_tuser),
        .i_a          (i_s_axis_tdata[7:0]),
        .i_b          (i_s_axis_tdata[15:8]),
        .i_queue_full (queue_full),
        .o_ready      (o_s_axis_tready),
        .o_push       (front_push),
        .o_item       (front_item)
    );

    alu8m_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_item  (front_item),
        .i_pop   (back_pop),
        .o_full  (queue_full),
        .o_empty (queue_empty),
        .o_item  (queue_item)
    );

    alu8m_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (queue_empty),
        .i_item  (queue_item),
        .o_pop   (back_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (back_res)
    );

    assign o_m_axis_tdata = back_res.value;
    assign o_m_axis_tuser = {back_res.err, back_res.wide};

endmodule

>>> bench/alu_result_checker.sv
// Result checker for the 8-bit multi-operation ALU: predicts each result and compares it.
module alu_result_checker
    import alu8m_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,
    input  logic [7:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,
    input  logic [2:0]  i_m_tuser,
    output int          o_pending,
    output int          o_mismatches,
    output int          o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    t_res expected_results [$];
    int   mismatch_count = 0;
    int   checked_count  = 0;

    assign o_mismatches = mismatch_count;
    assign o_checked    = checked_count;

    function automatic t_res predict_alu(input logic [7:0] opc, input logic [7:0] a,
                                         input logic [7:0] b);
        t_res res;
        int   ua;
        int   ub;
        int   sa;
        int   sb;
        int   acc;
        int   rem;
        res = '0;
        ua  = a;
        ub  = b;
        sa  = $signed(a);
        sb  = $signed(b);
        case (opc)
            OPC_SADD, OPC_SSUB: begin
                acc = (opc == OPC_SADD) ? sa + sb : sa - sb;
                if (acc < -128 || acc > 127) begin
                    res.err = ERR_OVERFLOW;
                end
                res.value = 16'(acc & 'hFF);
            end
            OPC_NEG:  res.value = 16'((0 - ua) & 'hFF);
            OPC_EQ:   res.value = 16'(ua == ub);
            OPC_LT:   res.value = 16'(ua < ub);
            OPC_GT:   res.value = 16'(ua > ub);
            OPC_AND:  res.value = 16'(ua & ub);
            OPC_OR:   res.value = 16'(ua | ub);
            OPC_SHL:  res.value = (ub >= 8) ? 16'd0 : 16'((ua << ub) & 'hFF);
            OPC_SHR:  res.value = (ub >= 8) ? 16'd0 : 16'(ua >> ub);
            OPC_UMUL: begin
                res.wide  = 1'b1;
                res.value = 16'(ua * ub);
            end
            OPC_SMUL: begin
                res.wide  = 1'b1;
                res.value = 16'(sa * sb);
            end
            OPC_UDIV: begin
                res.wide = 1'b1;
                if (ub == 0) begin
                    res.err = ERR_DIV_ZERO;
                end else begin
                    res.value = {8'(ua % ub), 8'(ua / ub)};
                end
            end
            OPC_SDIV: begin
                res.wide = 1'b1;
                if (sb == 0) begin
                    res.err = ERR_DIV_ZERO;
                end else begin
                    acc = sa / sb;
                    rem = sa % sb;
                    res.value = {8'(rem & 'hFF), 8'(acc & 'hFF)};
                end
            end
            OPC_ADD:  res.value = 16'((ua + ub) & 'hFF);
            OPC_SUB:  res.value = 16'((ua - ub) & 'hFF);
            default:  res = '0;
        endcase
        return res;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                expected_results.push_back(
                    predict_alu(i_s_tuser, i_s_tdata[7:0], i_s_tdata[15:8]));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t ns: result beat with nothing expected, actual 0x%0h / 0x%0h",
                             $time, i_m_tdata, i_m_tuser);
                end else begin
                    want = expected_results.pop_front();
                    checked_count++;
                    check_field("result_value", want.value, i_m_tdata);
                    check_field("result_is_wide", want.wide, i_m_tuser[0]);
                    check_field("error_code", want.err, i_m_tuser[2:1]);
                end
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

>>> bench/testbench.sv
// Top of the testbench for the 8-bit multi-operation ALU: stimulus, watchdog and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import alu8m_pkg::*;

    localparam int RANDOM_PER_PHASE = 440;
    localparam int DRAIN_CYCLES     = 24;
    localparam int QUIET_LIMIT      = 2000;

    localparam logic [7:0] OPC_GAP_LO  = OPC_SDIV + 8'd1;
    localparam logic [7:0] OPC_GAP_HI  = OPC_ADD - 8'd1;
    localparam logic [7:0] OPC_PAST    = OPC_SUB + 8'd1;
    localparam logic [7:0] OPC_TOPMOST = 8'hFF;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [7:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;

    int pending;
    int mismatches;
    int checked;
    int idle_pct     = 0;
    int stall_pct    = 0;
    int beats_sent   = 0;
    int quiet_cycles = 0;

    logic [7:0] opcodes [0:15] = '{
        OPC_SADD, OPC_SSUB, OPC_NEG, OPC_EQ, OPC_LT, OPC_GT, OPC_AND, OPC_OR,
        OPC_SHL, OPC_SHR, OPC_UMUL, OPC_SMUL, OPC_UDIV, OPC_SDIV, OPC_ADD, OPC_SUB
    };

    logic [7:0] edge_values [0:5] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'h81, 8'hFF};

    // Each entry is {opcode, operand_a, operand_b}.
    logic [23:0] directed_beats [0:27] = '{
        {OPC_SADD, 8'h7F, 8'h01}, {OPC_SADD, 8'h80, 8'hFF}, {OPC_SADD, 8'h40, 8'hC0},
        {OPC_SSUB, 8'h80, 8'h01}, {OPC_SSUB, 8'h7F, 8'hFF}, {OPC_NEG, 8'h00, 8'h00},
        {OPC_NEG, 8'h80, 8'h00},  {OPC_EQ, 8'hFF, 8'hFF},   {OPC_LT, 8'h00, 8'hFF},
        {OPC_GT, 8'hFF, 8'h00},   {OPC_AND, 8'hFF, 8'hA5},  {OPC_OR, 8'h00, 8'h5A},
        {OPC_SHL, 8'hFF, 8'h07},  {OPC_SHL, 8'hFF, 8'h08},  {OPC_SHR, 8'hFF, 8'hFF},
        {OPC_UMUL, 8'hFF, 8'hFF}, {OPC_SMUL, 8'h80, 8'h80}, {OPC_SMUL, 8'h7F, 8'h80},
        {OPC_UDIV, 8'hFF, 8'h00}, {OPC_UDIV, 8'hFF, 8'h01}, {OPC_SDIV, 8'h80, 8'hFF},
        {OPC_SDIV, 8'hF9, 8'h02}, {OPC_SDIV, 8'h12, 8'h00}, {OPC_ADD, 8'hFF, 8'hFF},
        {OPC_SUB, 8'h00, 8'h01},  {OPC_GAP_LO, 8'hFF, 8'hFF}, {OPC_GAP_HI, 8'hFF, 8'hFF},
        {OPC_PAST, 8'hFF, 8'hFF}
    };

    alu_8bit_multiop u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    alu_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_pending    (pending),
        .o_mismatches (mismatches),
        .o_checked    (checked)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        m_tready <= rst_n && ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    function automatic logic [7:0] pick_operand();
        if ($urandom_range(0, 3) == 0) begin
            return edge_values[$urandom_range(0, 5)];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_beat(input logic [7:0] opc, input logic [7:0] a, input logic [7:0] b);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tuser  <= opc;
        @(posedge clk);
        while (!s_tready) begin
            @(posedge clk);
        end
        beats_sent++;
    endtask

    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
    endtask

    initial begin
        int         phase;
        int         n;
        logic [7:0] opc;
        logic [7:0] a;
        logic [7:0] b;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_beats[i]) begin
            send_beat(directed_beats[i][23:16], directed_beats[i][15:8], directed_beats[i][7:0]);
        end
        send_beat(OPC_TOPMOST, 8'h00, 8'h00);
        for (phase = 0; phase < 4; phase++) begin
            wait_until_drained();
            case (phase)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 72; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 72; end
                default: begin idle_pct = 15; stall_pct <= 15; end
            endcase
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                if ($urandom_range(0, 99) < 85) begin
                    opc = opcodes[$urandom_range(0, 15)];
                end else begin
                    opc = 8'($urandom_range(0, 255));
                end
                a = pick_operand();
                b = pick_operand();
                if ((opc == OPC_SHL || opc == OPC_SHR) && $urandom_range(0, 1) == 1) begin
                    b = 8'($urandom_range(0, 9));
                end
                if ((opc == OPC_UDIV || opc == OPC_SDIV) && $urandom_range(0, 9) == 0) begin
                    b = 8'h00;
                end
                send_beat(opc, a, b);
            end
        end
        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d beats across four idling and stalling phases; %0d results compared.",
                 beats_sent, checked);
        $display("Covered every operation, signed overflow, long shifts, division by zero "
                 , "and unknown opcodes.");
        if (mismatches == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
